@@ hw/rtl/ama_pkg.sv @@
// Shared constants and helpers for the adaptive moving average unit.
// No dependencies; imported by every module of the block.
package ama_pkg;

    // Default sizes handed to the top level parameters
    localparam int MAX_PERIOD_DEF    = 64;
    localparam int PRICE_BITS_DEF    = 32;
    localparam int FRACTION_BITS_DEF = 16;

    // Extra fraction bits carried by the internal average
    localparam int GUARD_BITS = 8;

    // Configuration register
    localparam int              CFG_W        = 7;
    localparam logic [CFG_W-1:0] PERIOD_RESET = 7'd20;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Round a bit count up to whole bytes
    function automatic int byte_pad(input int bits);
        return ((bits + 7) >> 3) << 3;
    endfunction

endpackage

@@ hw/rtl/ama_queue.sv @@
// Small first-in first-out queue between the front and back sections.
// Depends on ama_pkg for the default depth.
module ama_queue
    import ama_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] rdata
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign valid   = (count_reg != '0);
    assign rdata   = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ hw/rtl/ama_front.sv @@
// Front section: holds the period register, accepts samples, tracks the
// window fill and classifies each sample. Depends on ama_pkg.
module ama_front
    import ama_pkg::*;
#(
    parameter int MAX_PERIOD = MAX_PERIOD_DEF,
    parameter int PRICE_BITS = PRICE_BITS_DEF,
    parameter int CNT_W      = $clog2(MAX_PERIOD + 2)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [PRICE_BITS-1:0] in_price,
    input  logic                  in_restart,
    output logic                  q_push,
    output logic [PRICE_BITS+CNT_W:0] q_wdata,   // {fresh, steps, price}
    input  logic                  q_full
);

    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    logic [CFG_W-1:0] period_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CMP_W-1:0] cfg_ext;
    logic [CNT_W-1:0] period_eff;
    logic [CNT_W:0]   cnt_inc;
    logic [CNT_W:0]   cnt_cap;
    logic             fresh;
    logic [CNT_W-1:0] steps;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    // Clamp the period into 1..MAX_PERIOD
    assign cfg_ext = CMP_W'(period_reg);
    always_comb
    begin
        priority if (period_reg == '0)
        begin
            period_eff = CNT_W'(1);
        end
        else if (cfg_ext > CMP_W'(MAX_PERIOD))
        begin
            period_eff = CNT_W'(MAX_PERIOD);
        end
        else
        begin
            period_eff = cfg_ext[CNT_W-1:0];
        end
    end

    // Window fill, saturating at period + 1
    assign fresh   = in_restart || (cnt_reg == '0);
    assign cnt_inc = {1'b0, cnt_reg} + 1'b1;
    assign cnt_cap = {1'b0, period_eff} + 1'b1;
    assign cnt_next = fresh ? CNT_W'(1)
                    : ((cnt_inc > cnt_cap) ? cnt_cap[CNT_W-1:0] : cnt_inc[CNT_W-1:0]);
    assign steps   = cnt_next - 1'b1;
    assign q_wdata = {fresh, steps, in_price};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
            cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                period_reg <= cfg_wdata;
            end
            if (q_push)
            begin
                cnt_reg <= cnt_next;
            end
        end
    end

endmodule

@@ hw/rtl/ama_back.sv @@
// Back section: price ring, step-sum scan, ratio divider, smoothing
// constant and average update, with the output register. Depends on ama_pkg.
module ama_back
    import ama_pkg::*;
#(
    parameter int MAX_PERIOD    = MAX_PERIOD_DEF,
    parameter int PRICE_BITS    = PRICE_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int CNT_W         = $clog2(MAX_PERIOD + 2)
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  logic [PRICE_BITS+CNT_W:0]  q_rdata,   // {fresh, steps, price}
    output logic                       q_pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [PRICE_BITS-1:0]      out_average,
    output logic [FRACTION_BITS:0]     out_efficiency
);

    localparam int F      = FRACTION_BITS;
    localparam int DEPTH  = MAX_PERIOD + 1;
    localparam int AW     = $clog2(DEPTH);
    localparam int SUM_W  = PRICE_BITS + 8;
    localparam int CHG_W  = PRICE_BITS + 1;
    localparam int SM_W   = PRICE_BITS + GUARD_BITS;
    localparam int MAG_W  = SM_W + 1;
    localparam int SPLIT  = MAG_W / 2;
    localparam int HI_W   = MAG_W - SPLIT;
    localparam int EFF_W  = F + 1;
    localparam int QC_W   = $clog2(F);
    localparam int A_W    = 2 * F + 3;
    localparam int P_W    = EFF_W + MAG_W + 1;

    localparam longint unsigned ONE      = 64'd1 << F;
    localparam longint unsigned HALF     = 64'd1 << (F - 1);
    localparam longint unsigned SLOW     = (2 * ONE + 15) / 31;
    localparam longint unsigned FAST     = (2 * ONE + 1) / 3;
    localparam longint unsigned SLOW_ONE = SLOW * ONE + HALF;
    localparam logic [F-1:0]    FS_DIFF  = F'(FAST - SLOW);

    // Sequencer codes
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SCAN  = 4'd1;
    localparam logic [3:0] ST_DINIT = 4'd2;
    localparam logic [3:0] ST_DIV   = 4'd3;
    localparam logic [3:0] ST_ALPHA = 4'd4;
    localparam logic [3:0] ST_SQ    = 4'd5;
    localparam logic [3:0] ST_DIFF  = 4'd6;
    localparam logic [3:0] ST_MULLO = 4'd7;
    localparam logic [3:0] ST_MULHI = 4'd8;
    localparam logic [3:0] ST_ACC   = 4'd9;
    localparam logic [3:0] ST_UPD   = 4'd10;
    localparam logic [3:0] ST_OUT   = 4'd11;

    logic [PRICE_BITS-1:0] ring [DEPTH];

    logic [3:0]              state_reg;
    logic [3:0]              state_next;
    logic signed [PRICE_BITS-1:0] price_reg;
    logic [CNT_W-1:0]        n_reg;
    logic [AW-1:0]           ptr_reg;
    logic [AW-1:0]           rd_addr_reg;
    logic [CNT_W-1:0]        issued_reg;
    logic [CNT_W-1:0]        consumed_reg;
    logic                    rdv_reg;
    logic signed [PRICE_BITS-1:0] rdata_reg;
    logic signed [PRICE_BITS-1:0] prev_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [CHG_W-1:0]        change_reg;
    logic [SUM_W:0]          rem_reg;
    logic [F-1:0]            quo_reg;
    logic [QC_W-1:0]         qcnt_reg;
    logic [EFF_W-1:0]        eff_reg;
    logic [EFF_W-1:0]        alpha_reg;
    logic [EFF_W-1:0]        sc_reg;
    logic                    neg_reg;
    logic [MAG_W-1:0]        mag_reg;
    logic [EFF_W+SPLIT-1:0]  plo_reg;
    logic [EFF_W+HI_W-1:0]   phi_reg;
    logic [MAG_W-1:0]        step_reg;
    logic signed [SM_W-1:0]  smooth_reg;
    logic                    out_valid_reg;
    logic [PRICE_BITS-1:0]   out_avg_reg;
    logic [EFF_W-1:0]        out_eff_reg;

    logic signed [PRICE_BITS-1:0] q_price;
    logic [CNT_W-1:0]        q_steps;
    logic                    q_fresh;
    logic                    out_free;
    logic                    scan_issue;
    logic                    scan_last;
    logic signed [CHG_W-1:0] step_d;
    logic [CHG_W-1:0]        step_mag;
    logic signed [CHG_W-1:0] chg_d;
    logic [CHG_W-1:0]        chg_mag;
    logic [SUM_W:0]          sum_wide;
    logic [SUM_W-1:0]        sum_sat;
    logic [SUM_W:0]          rem_shift;
    logic                    rem_ge;
    logic [SUM_W:0]          rem_next;
    logic [F-1:0]            quo_next;
    logic [EFF_W+F-1:0]      a_prod;
    logic [A_W-1:0]          a_sum;
    logic [2*EFF_W-1:0]      sq_sum;
    logic signed [MAG_W-1:0] diff_val;
    logic [P_W-1:0]          acc_sum;
    logic signed [SM_W:0]    avg_wide;

    assign q_price  = q_rdata[PRICE_BITS-1:0];
    assign q_steps  = q_rdata[PRICE_BITS +: CNT_W];
    assign q_fresh  = q_rdata[PRICE_BITS+CNT_W];
    assign out_free = !out_valid_reg || out_ready;
    assign q_pop    = (state_reg == ST_IDLE) && q_valid && out_free;

    assign out_valid      = out_valid_reg;
    assign out_average    = out_avg_reg;
    assign out_efficiency = out_eff_reg;

    // Window scan: one ring read issued and one step summed per cycle
    assign scan_issue = (state_reg == ST_SCAN) && (issued_reg != n_reg);
    assign scan_last  = rdv_reg && (consumed_reg == n_reg - 1'b1);
    assign step_d     = {prev_reg[PRICE_BITS-1], prev_reg}
                      - {rdata_reg[PRICE_BITS-1], rdata_reg};
    assign step_mag   = step_d[CHG_W-1] ? CHG_W'(-step_d) : CHG_W'(step_d);
    assign chg_d      = {price_reg[PRICE_BITS-1], price_reg}
                      - {rdata_reg[PRICE_BITS-1], rdata_reg};
    assign chg_mag    = chg_d[CHG_W-1] ? CHG_W'(-chg_d) : CHG_W'(chg_d);
    assign sum_wide   = {1'b0, sum_reg} + (SUM_W+1)'(step_mag);
    assign sum_sat    = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];

    // Restoring divider, one quotient bit per cycle
    assign rem_shift = {rem_reg[SUM_W-1:0], 1'b0};
    assign rem_ge    = (rem_shift >= {1'b0, sum_reg});
    assign rem_next  = rem_ge ? (rem_shift - {1'b0, sum_reg}) : rem_shift;
    assign quo_next  = {quo_reg[F-2:0], rem_ge};

    // Smoothing constant pieces
    assign a_prod   = (EFF_W+F)'(eff_reg) * (EFF_W+F)'(FS_DIFF);
    assign a_sum    = A_W'(SLOW_ONE) + A_W'(a_prod);
    assign sq_sum   = (2*EFF_W)'(alpha_reg) * (2*EFF_W)'(alpha_reg) + (2*EFF_W)'(HALF);
    assign diff_val = $signed({price_reg[PRICE_BITS-1], price_reg, {GUARD_BITS{1'b0}}})
                    - $signed({smooth_reg[SM_W-1], smooth_reg});
    assign acc_sum  = (P_W'(phi_reg) << SPLIT) + P_W'(plo_reg) + P_W'(HALF);
    assign avg_wide = $signed({smooth_reg[SM_W-1], smooth_reg})
                    + $signed((SM_W+1)'(1) << (GUARD_BITS - 1));

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    state_next = q_fresh ? ST_OUT : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_DINIT;
                end
            end
            ST_DINIT:
            begin
                if (sum_reg == '0 || SUM_W'(change_reg) >= sum_reg)
                begin
                    state_next = ST_ALPHA;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (qcnt_reg == QC_W'(F - 1))
                begin
                    state_next = ST_ALPHA;
                end
            end
            ST_ALPHA: state_next = ST_SQ;
            ST_SQ:    state_next = ST_DIFF;
            ST_DIFF:  state_next = ST_MULLO;
            ST_MULLO: state_next = ST_MULHI;
            ST_MULHI: state_next = ST_ACC;
            ST_ACC:   state_next = ST_UPD;
            ST_UPD:   state_next = ST_OUT;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Ring memory: written on pop, read with a registered output
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            ring[ptr_reg] <= q_price;
        end
        rdata_reg <= ring[rd_addr_reg];
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    price_reg   <= q_price;
                    n_reg       <= q_steps;
                    prev_reg    <= q_price;
                    sum_reg     <= '0;
                    issued_reg  <= '0;
                    consumed_reg <= '0;
                    rd_addr_reg <= (ptr_reg == '0) ? AW'(DEPTH - 1) : ptr_reg - 1'b1;
                    if (q_fresh)
                    begin
                        smooth_reg <= {q_price, {GUARD_BITS{1'b0}}};
                        eff_reg    <= '0;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_issue)
                begin
                    issued_reg  <= issued_reg + 1'b1;
                    rd_addr_reg <= (rd_addr_reg == '0) ? AW'(DEPTH - 1) : rd_addr_reg - 1'b1;
                end
                if (rdv_reg)
                begin
                    sum_reg      <= sum_sat;
                    prev_reg     <= rdata_reg;
                    consumed_reg <= consumed_reg + 1'b1;
                    change_reg   <= chg_mag;
                end
            end
            ST_DINIT:
            begin
                rem_reg  <= (SUM_W+1)'(change_reg);
                quo_reg  <= '0;
                qcnt_reg <= '0;
                priority if (sum_reg == '0)
                begin
                    eff_reg <= '0;
                end
                else if (SUM_W'(change_reg) >= sum_reg)
                begin
                    eff_reg <= EFF_W'(ONE);
                end
                else
                begin
                    eff_reg <= eff_reg;
                end
            end
            ST_DIV:
            begin
                rem_reg  <= rem_next;
                quo_reg  <= quo_next;
                qcnt_reg <= qcnt_reg + 1'b1;
                if (qcnt_reg == QC_W'(F - 1))
                begin
                    eff_reg <= {1'b0, quo_next};
                end
            end
            ST_ALPHA: alpha_reg <= a_sum[F +: EFF_W];
            ST_SQ:    sc_reg    <= sq_sum[F +: EFF_W];
            ST_DIFF:
            begin
                neg_reg <= diff_val[MAG_W-1];
                mag_reg <= diff_val[MAG_W-1] ? MAG_W'(-diff_val) : MAG_W'(diff_val);
            end
            ST_MULLO: plo_reg  <= (EFF_W+SPLIT)'(sc_reg)
                                * (EFF_W+SPLIT)'(mag_reg[SPLIT-1:0]);
            ST_MULHI: phi_reg  <= (EFF_W+HI_W)'(sc_reg)
                                * (EFF_W+HI_W)'(mag_reg[MAG_W-1:SPLIT]);
            ST_ACC:   step_reg <= acc_sum[F +: MAG_W];
            ST_UPD:
            begin
                smooth_reg <= neg_reg ? smooth_reg - $signed(step_reg[SM_W-1:0])
                                      : smooth_reg + $signed(step_reg[SM_W-1:0]);
            end
            ST_OUT:
            begin
                out_avg_reg <= avg_wide[GUARD_BITS +: PRICE_BITS];
                out_eff_reg <= eff_reg;
            end
            default:
            begin
                price_reg <= price_reg;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= '0;
            rdv_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rdv_reg   <= scan_issue;
            if (q_pop)
            begin
                ptr_reg <= (ptr_reg == AW'(DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
            end
            if (state_reg == ST_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

@@ hw/rtl/adaptive_moving_average_unit.sv @@
// Top level of the adaptive moving average unit (fast 2, slow 30).
// Depends on ama_pkg, ama_front, ama_queue and ama_back.
//
//  Channel   Direction  Transaction contents
//  s_axis    in         tdata: price; tuser: restart
//  m_axis    out        tdata: average, efficiency
//  cfg       in         cfg_wdata: window period, written when cfg_we is high
//
// For a sample in a running series the back section scans the n price steps
// in the window (up to MAX_PERIOD), reading one ring entry per cycle, then
// runs the ratio divider unless the step sum is zero or the net change reaches
// it. A first sample or restart goes straight to the output register.
// Reset sets the period to 20 and clears the fill count, the pointer and the output valid flag.
// The front keeps accepting while the queue has room, so a stalled output
// only stops intake once the queue is full.
module adaptive_moving_average_unit
    import ama_pkg::*;
#(
    parameter int MAX_PERIOD    = MAX_PERIOD_DEF,
    parameter int PRICE_BITS    = PRICE_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int IN_TD_W       = byte_pad(PRICE_BITS),
    parameter int OUT_TD_W      = byte_pad(PRICE_BITS + FRACTION_BITS + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [IN_TD_W-1:0]  s_axis_tdata,   // price
    input  logic [0:0]          s_axis_tuser,   // restart
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OUT_TD_W-1:0] m_axis_tdata,   // average, efficiency
    input  logic                cfg_we,
    input  logic [CFG_W-1:0]    cfg_wdata
);

    localparam int CNT_W = $clog2(MAX_PERIOD + 2);
    localparam int Q_W   = PRICE_BITS + CNT_W + 1;

    logic                     q_push;
    logic [Q_W-1:0]           q_wdata;
    logic                     q_full;
    logic                     q_pop;
    logic                     q_valid;
    logic [Q_W-1:0]           q_rdata;
    logic [PRICE_BITS-1:0]    avg;
    logic [FRACTION_BITS:0]   eff;

    ama_front #(
        .MAX_PERIOD (MAX_PERIOD),
        .PRICE_BITS (PRICE_BITS),
        .CNT_W      (CNT_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_price   (s_axis_tdata[PRICE_BITS-1:0]),
        .in_restart (s_axis_tuser[0]),
        .q_push     (q_push),
        .q_wdata    (q_wdata),
        .q_full     (q_full)
    );

    ama_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .valid (q_valid),
        .rdata (q_rdata)
    );

    ama_back #(
        .MAX_PERIOD    (MAX_PERIOD),
        .PRICE_BITS    (PRICE_BITS),
        .FRACTION_BITS (FRACTION_BITS),
        .CNT_W         (CNT_W)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_rdata        (q_rdata),
        .q_pop          (q_pop),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_average    (avg),
        .out_efficiency (eff)
    );

    // Pack results, zero padded to whole bytes
    assign m_axis_tdata = OUT_TD_W'({eff, avg});

endmodule
